FILE: rtl/wake_time_task_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Wake-time task scheduler assertion macros
// Concurrent assertion helpers sampled on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef WAKE_TIME_TASK_SCHEDULER_TOP_DEFINES_SVH
`define WAKE_TIME_TASK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define WTTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WTTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WTTS_ASSERT_IMP(lbl, ante, cons, msg)
`define WTTS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/wtts_pkg.sv
// ----------------------------------------------------------------------------
// Wake-time task scheduler package
// Shared codes, defaults and types of the scheduler, its cells and control.
// ----------------------------------------------------------------------------
package wtts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [15:0] IDLE_SLEEP_RESET = 16'd10;

    // Operation codes.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_RESUME = 3'd2;
    localparam logic [2:0] OP_POLL   = 3'd3;
    localparam logic [2:0] OP_REPORT = 3'd4;

    // Report outcomes.
    localparam logic [1:0] OC_DONE    = 2'd0;
    localparam logic [1:0] OC_SUSPEND = 2'd1;
    localparam logic [1:0] OC_REQUEUE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Slot update broadcast to the cells.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ADD,
        CMD_CLEAR,
        CMD_QUEUE,
        CMD_UNQUEUE,
        CMD_SUSPEND
    } t_cmd;

    // Flags of the search probe that walks the cell chain.
    typedef struct packed {
        logic found;
        logic found_queued;
        logic found_susp;
        logic free_hit;
        logic best_hit;
    } t_probe_flags;

endpackage

FILE: rtl/wtts_cell.sv
// ----------------------------------------------------------------------------
// Wake-time task scheduler cell
// One table slot plus one stage of the search probe handed down the chain.
// ----------------------------------------------------------------------------
module wtts_cell #(
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = wtts_pkg::TIME_BITS_DEF,
    parameter int SLOT_IDX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // search key and slot update, broadcast to every cell
    input  logic [7:0]            i_id,
    input  wtts_pkg::t_cmd        i_cmd,
    input  logic [IDX_W-1:0]      i_cmd_idx,
    input  logic [TIME_BITS-1:0]  i_cmd_wake,
    // probe from the previous cell
    input  wtts_pkg::t_probe_flags i_flags,
    input  logic [IDX_W-1:0]      i_found_idx,
    input  logic [IDX_W-1:0]      i_free_idx,
    input  logic [IDX_W-1:0]      i_best_idx,
    input  logic [TIME_BITS-1:0]  i_best_wake,
    input  logic [7:0]            i_best_task,
    // probe to the next cell
    output wtts_pkg::t_probe_flags o_flags,
    output logic [IDX_W-1:0]      o_found_idx,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [TIME_BITS-1:0]  o_best_wake,
    output logic [7:0]            o_best_task,
    // slot flags for the summary outputs
    output logic                  o_slot_valid,
    output logic                  o_slot_queued,
    output logic                  o_slot_susp
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(SLOT_IDX);

    logic                  r_valid;
    logic                  r_queued;
    logic                  r_susp;
    logic [7:0]            r_task;
    logic [TIME_BITS-1:0]  r_wake;

    wtts_pkg::t_probe_flags r_flags;
    logic [IDX_W-1:0]      r_found_idx;
    logic [IDX_W-1:0]      r_free_idx;
    logic [IDX_W-1:0]      r_best_idx;
    logic [TIME_BITS-1:0]  r_best_wake;
    logic [7:0]            r_best_task;

    logic w_hit;
    logic w_match;
    logic w_take_free;
    logic w_take_best;

    assign w_hit       = (i_cmd_idx == MyIdx);
    assign w_match     = r_valid && (r_task == i_id);
    assign w_take_free = !i_flags.free_hit && !r_valid;
    // Strictly earlier wins, so equal wake times keep the lower slot.
    assign w_take_best = r_valid && r_queued &&
                         (!i_flags.best_hit || (r_wake < i_best_wake));

    // Slot flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_queued <= 1'b0;
            r_susp   <= 1'b0;
        end else if (w_hit) begin
            unique case (i_cmd)
                wtts_pkg::CMD_ADD: begin
                    r_valid  <= 1'b1;
                    r_queued <= 1'b1;
                    r_susp   <= 1'b0;
                end
                wtts_pkg::CMD_CLEAR: begin
                    r_valid  <= 1'b0;
                    r_queued <= 1'b0;
                    r_susp   <= 1'b0;
                end
                wtts_pkg::CMD_QUEUE: begin
                    r_queued <= 1'b1;
                    r_susp   <= 1'b0;
                end
                wtts_pkg::CMD_UNQUEUE: begin
                    r_queued <= 1'b0;
                end
                wtts_pkg::CMD_SUSPEND: begin
                    r_susp <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Slot payload.
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            unique case (i_cmd)
                wtts_pkg::CMD_ADD: begin
                    r_task <= i_id;
                    r_wake <= '0;
                end
                wtts_pkg::CMD_QUEUE: begin
                    r_wake <= i_cmd_wake;
                end
                default: begin
                end
            endcase
        end
    end

    // Probe stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.found        <= i_flags.found || w_match;
            r_flags.found_queued <= i_flags.found ? i_flags.found_queued : r_queued;
            r_flags.found_susp   <= i_flags.found ? i_flags.found_susp : r_susp;
            r_flags.free_hit     <= i_flags.free_hit || w_take_free;
            r_flags.best_hit     <= i_flags.best_hit || w_take_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found_idx <= (i_flags.found || !w_match) ? i_found_idx : MyIdx;
        r_free_idx  <= w_take_free ? MyIdx : i_free_idx;
        r_best_idx  <= w_take_best ? MyIdx : i_best_idx;
        r_best_wake <= w_take_best ? r_wake : i_best_wake;
        r_best_task <= w_take_best ? r_task : i_best_task;
    end

    assign o_flags       = r_flags;
    assign o_found_idx   = r_found_idx;
    assign o_free_idx    = r_free_idx;
    assign o_best_idx    = r_best_idx;
    assign o_best_wake   = r_best_wake;
    assign o_best_task   = r_best_task;
    assign o_slot_valid  = r_valid;
    assign o_slot_queued = r_queued;
    assign o_slot_susp   = r_susp;

endmodule

FILE: rtl/wtts_ctrl.sv
// ----------------------------------------------------------------------------
// Wake-time task scheduler control
// Sequences one operation: probe sweep, decision, slot update, result word.
// ----------------------------------------------------------------------------
module wtts_ctrl #(
    parameter int MAX_TASKS = wtts_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = wtts_pkg::TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    // input word
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_opcode,
    input  logic [7:0]             i_task_id,
    input  logic [31:0]            i_now,
    input  logic [1:0]             i_outcome,
    input  logic [31:0]            i_wake_time,
    // probe leaving the last cell
    input  wtts_pkg::t_probe_flags i_flags,
    input  logic [IDX_W-1:0]       i_found_idx,
    input  logic [IDX_W-1:0]       i_free_idx,
    input  logic [IDX_W-1:0]       i_best_idx,
    input  logic [TIME_BITS-1:0]   i_best_wake,
    input  logic [7:0]             i_best_task,
    input  logic [MAX_TASKS-1:0]   i_slot_valid,
    input  logic [MAX_TASKS-1:0]   i_slot_queued,
    // broadcast to the cells
    output logic [7:0]             o_id,
    output wtts_pkg::t_cmd         o_cmd,
    output logic [IDX_W-1:0]       o_cmd_idx,
    output logic [TIME_BITS-1:0]   o_cmd_wake,
    // result word
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic                   o_granted,
    output logic [7:0]             o_granted_id,
    output logic [31:0]            o_sleep_ticks,
    output logic                   o_queue_empty,
    output logic                   o_table_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DECIDE,
        S_APPLY,
        S_SUM
    } t_state;

    localparam logic [IDX_W-1:0] LastCnt = IDX_W'(MAX_TASKS - 1);

    t_state                r_state;
    logic [IDX_W-1:0]      r_cnt;
    logic [15:0]           r_idle;
    logic [2:0]            r_op;
    logic [7:0]            r_id;
    logic [TIME_BITS-1:0]  r_now;
    logic [1:0]            r_outcome;
    logic [TIME_BITS-1:0]  r_wake;

    wtts_pkg::t_cmd        r_cmd;
    logic [IDX_W-1:0]      r_cmd_idx;
    logic [TIME_BITS-1:0]  r_cmd_wake;

    logic [1:0]            r_res_status;
    logic                  r_res_granted;
    logic [7:0]            r_res_gid;
    logic [31:0]           r_res_sleep;

    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic                  r_granted;
    logic [7:0]            r_granted_id;
    logic [31:0]           r_sleep_ticks;
    logic                  r_queue_empty;
    logic                  r_table_empty;

    wtts_pkg::t_cmd        n_cmd;
    logic [IDX_W-1:0]      n_cmd_idx;
    logic [TIME_BITS-1:0]  n_cmd_wake;
    logic [1:0]            n_status;
    logic                  n_granted;
    logic [7:0]            n_gid;
    logic [31:0]           n_sleep;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_due;
    logic [TIME_BITS-1:0]  w_diff;
    logic [31:0]           w_diff32;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_due      = (i_best_wake <= r_now);
    assign w_diff     = i_best_wake - r_now;

    // Sleep lengths wider than the result field saturate.
    if (TIME_BITS > 32) begin : g_sat
        assign w_diff32 = (|w_diff[TIME_BITS-1:32]) ? '1 : w_diff[31:0];
    end else begin : g_nosat
        assign w_diff32 = 32'(w_diff);
    end

    // Decision on the swept probe.
    always_comb begin
        n_cmd      = wtts_pkg::CMD_NONE;
        n_cmd_idx  = i_found_idx;
        n_cmd_wake = r_wake;
        n_status   = wtts_pkg::ST_MISS;
        n_granted  = 1'b0;
        n_gid      = '0;
        n_sleep    = '0;
        unique case (r_op)
            wtts_pkg::OP_ADD: begin
                n_status = wtts_pkg::ST_FULL;
                if (!i_flags.found && i_flags.free_hit) begin
                    n_cmd     = wtts_pkg::CMD_ADD;
                    n_cmd_idx = i_free_idx;
                    n_status  = wtts_pkg::ST_OK;
                end
            end
            wtts_pkg::OP_STOP: begin
                if (i_flags.found) begin
                    n_cmd    = wtts_pkg::CMD_CLEAR;
                    n_status = wtts_pkg::ST_OK;
                end
            end
            wtts_pkg::OP_RESUME: begin
                if (i_flags.found && i_flags.found_susp) begin
                    n_cmd      = wtts_pkg::CMD_QUEUE;
                    n_cmd_wake = r_now;
                    n_status   = wtts_pkg::ST_OK;
                end
            end
            wtts_pkg::OP_POLL: begin
                n_status  = wtts_pkg::ST_OK;
                n_cmd_idx = i_best_idx;
                if (!i_flags.best_hit) begin
                    n_sleep = 32'(r_idle);
                end else if (w_due) begin
                    n_cmd     = wtts_pkg::CMD_UNQUEUE;
                    n_granted = 1'b1;
                    n_gid     = i_best_task;
                end else begin
                    n_sleep = w_diff32;
                end
            end
            wtts_pkg::OP_REPORT: begin
                if (i_flags.found && !i_flags.found_queued && !i_flags.found_susp) begin
                    priority if (r_outcome == wtts_pkg::OC_DONE) begin
                        n_cmd    = wtts_pkg::CMD_CLEAR;
                        n_status = wtts_pkg::ST_OK;
                    end else if (r_outcome == wtts_pkg::OC_SUSPEND) begin
                        n_cmd    = wtts_pkg::CMD_SUSPEND;
                        n_status = wtts_pkg::ST_OK;
                    end else if (r_outcome == wtts_pkg::OC_REQUEUE) begin
                        n_cmd    = wtts_pkg::CMD_QUEUE;
                        n_status = wtts_pkg::ST_OK;
                    end else begin
                        n_status = wtts_pkg::ST_MISS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= wtts_pkg::IDLE_SLEEP_RESET;
        end else if (i_cfg_we) begin
            r_idle <= i_cfg_wdata;
        end
    end

    // Operand capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_opcode;
            r_id      <= i_task_id;
            r_now     <= TIME_BITS'(i_now);
            r_outcome <= i_outcome;
            r_wake    <= TIME_BITS'(i_wake_time);
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cmd       <= wtts_pkg::CMD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            // The summary step reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_SUM)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept) begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LastCnt) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cmd         <= n_cmd;
                    r_cmd_idx     <= n_cmd_idx;
                    r_cmd_wake    <= n_cmd_wake;
                    r_res_status  <= n_status;
                    r_res_granted <= n_granted;
                    r_res_gid     <= n_gid;
                    r_res_sleep   <= n_sleep;
                    r_state       <= S_APPLY;
                end
                S_APPLY: begin
                    r_cmd   <= wtts_pkg::CMD_NONE;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_status      <= r_res_status;
                        r_granted     <= r_res_granted;
                        r_granted_id  <= r_res_gid;
                        r_sleep_ticks <= r_res_sleep;
                        r_queue_empty <= ~|(i_slot_valid & i_slot_queued);
                        r_table_empty <= ~|i_slot_valid;
                        r_state       <= S_IDLE;
                    end else if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_id          = r_id;
    assign o_cmd         = r_cmd;
    assign o_cmd_idx     = r_cmd_idx;
    assign o_cmd_wake    = r_cmd_wake;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_granted     = r_granted;
    assign o_granted_id  = r_granted_id;
    assign o_sleep_ticks = r_sleep_ticks;
    assign o_queue_empty = r_queue_empty;
    assign o_table_empty = r_table_empty;

endmodule

FILE: rtl/wake_time_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// Wake-time task scheduler
// Task table with earliest-wake-time polling, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The scheduler keeps up to MAX_TASKS tasks, one per cell of a linear chain,
// and takes one operation word at a time: add, stop, resume, poll or report.
// Every operation sends a search probe down the chain, one cell per clock;
// the probe collects the slot that holds the named task, the lowest free slot
// and the queued slot with the earliest wake time (lower slot on a tie). The
// control then decides, broadcasts one slot update to the cells, and builds
// the result word from the updated slot flags. The input is taken again as
// soon as the result sits in the output register, so a result that waits on
// the output side does not hold up the next word. Times are handled TIME_BITS
// wide and compared as plain unsigned values; a sleep length wider than 32
// bits saturates. The idle sleep length register resets to 10 ticks and is
// written through i_cfg_we / i_cfg_wdata; the user is to write it only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "wake_time_task_scheduler_top_defines.svh"

module wake_time_task_scheduler_top #(
    parameter int MAX_TASKS = wtts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = wtts_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Idle sleep length register.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Operation words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] task_id, [39:8] now, [41:40] outcome, [73:42] wake_time, rest zero
    input  logic [79:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_axis_tuser,
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] granted, [10:3] granted_id, [42:11] sleep_ticks,
    // [43] queue_empty, [44] table_empty, rest zero
    output logic [47:0] m_axis_tdata
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Probe links between cells; link 0 is the empty probe fed to cell 0.
    wtts_pkg::t_probe_flags w_flags     [MAX_TASKS+1];
    logic [IDX_W-1:0]       w_found_idx [MAX_TASKS+1];
    logic [IDX_W-1:0]       w_free_idx  [MAX_TASKS+1];
    logic [IDX_W-1:0]       w_best_idx  [MAX_TASKS+1];
    logic [TIME_BITS-1:0]   w_best_wake [MAX_TASKS+1];
    logic [7:0]             w_best_task [MAX_TASKS+1];

    logic [MAX_TASKS-1:0]   w_slot_valid;
    logic [MAX_TASKS-1:0]   w_slot_queued;
    logic [MAX_TASKS-1:0]   w_slot_susp;

    logic [7:0]             w_id;
    wtts_pkg::t_cmd         w_cmd;
    logic [IDX_W-1:0]       w_cmd_idx;
    logic [TIME_BITS-1:0]   w_cmd_wake;

    logic [1:0]             w_status;
    logic                   w_granted;
    logic [7:0]             w_granted_id;
    logic [31:0]            w_sleep_ticks;
    logic                   w_queue_empty;
    logic                   w_table_empty;

    assign w_flags[0]     = '0;
    assign w_found_idx[0] = '0;
    assign w_free_idx[0]  = '0;
    assign w_best_idx[0]  = '0;
    assign w_best_wake[0] = '0;
    assign w_best_task[0] = '0;

    // The slot chain: each cell owns one table entry and one probe stage.
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        wtts_cell #(
            .IDX_W     (IDX_W),
            .TIME_BITS (TIME_BITS),
            .SLOT_IDX  (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_id          (w_id),
            .i_cmd         (w_cmd),
            .i_cmd_idx     (w_cmd_idx),
            .i_cmd_wake    (w_cmd_wake),
            .i_flags       (w_flags[g]),
            .i_found_idx   (w_found_idx[g]),
            .i_free_idx    (w_free_idx[g]),
            .i_best_idx    (w_best_idx[g]),
            .i_best_wake   (w_best_wake[g]),
            .i_best_task   (w_best_task[g]),
            .o_flags       (w_flags[g+1]),
            .o_found_idx   (w_found_idx[g+1]),
            .o_free_idx    (w_free_idx[g+1]),
            .o_best_idx    (w_best_idx[g+1]),
            .o_best_wake   (w_best_wake[g+1]),
            .o_best_task   (w_best_task[g+1]),
            .o_slot_valid  (w_slot_valid[g]),
            .o_slot_queued (w_slot_queued[g]),
            .o_slot_susp   (w_slot_susp[g])
        );
    end

    // Sequencer, decision logic, configuration and the output register.
    wtts_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_task_id     (s_axis_tdata[7:0]),
        .i_now         (s_axis_tdata[39:8]),
        .i_outcome     (s_axis_tdata[41:40]),
        .i_wake_time   (s_axis_tdata[73:42]),
        .i_flags       (w_flags[MAX_TASKS]),
        .i_found_idx   (w_found_idx[MAX_TASKS]),
        .i_free_idx    (w_free_idx[MAX_TASKS]),
        .i_best_idx    (w_best_idx[MAX_TASKS]),
        .i_best_wake   (w_best_wake[MAX_TASKS]),
        .i_best_task   (w_best_task[MAX_TASKS]),
        .i_slot_valid  (w_slot_valid),
        .i_slot_queued (w_slot_queued),
        .o_id          (w_id),
        .o_cmd         (w_cmd),
        .o_cmd_idx     (w_cmd_idx),
        .o_cmd_wake    (w_cmd_wake),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_granted     (w_granted),
        .o_granted_id  (w_granted_id),
        .o_sleep_ticks (w_sleep_ticks),
        .o_queue_empty (w_queue_empty),
        .o_table_empty (w_table_empty)
    );

    assign m_axis_tdata = {3'b000, w_table_empty, w_queue_empty, w_sleep_ticks,
                           w_granted_id, w_granted, w_status};

    // A slot is only queued or suspended while it holds a task, and a
    // suspended task is never queued at the same time.
    `WTTS_ASSERT_IMP(a_flags_consistent, 1'b1, ((w_slot_queued | w_slot_susp) & ~w_slot_valid) == '0 && (w_slot_queued & w_slot_susp) == '0, "slot flags inconsistent")

    // One operation at a time: an accepted word closes the input until done.
    `WTTS_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an operation is in flight")

    // A grant always comes with status ok and no sleep length.
    `WTTS_ASSERT_IMP(a_grant_result, m_axis_tvalid && w_granted, w_status == wtts_pkg::ST_OK && w_sleep_ticks == '0, "grant with bad status or sleep")

    // An empty table cannot leave anything in the queue.
    `WTTS_ASSERT_IMP(a_empty_table, m_axis_tvalid && w_table_empty, w_queue_empty, "queue not empty with an empty table")

endmodule
